// ----- rtl/ecl_pkg.sv -----
`timescale 1ns / 1ps

package ecl_pkg;

	localparam int NumFloorsDef = 128;
	localparam int FloorW       = 7;
	localparam int PendW        = 8;

	// Comparison that a cell applies when the new floor sits just behind it.
	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_GT,
		MODE_LT,
		MODE_GT_BELOW,
		MODE_LT_ABOVE
	} swap_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PHA,
		ST_PHB
	} state_t;

	// Control broadcast from the sequencer to every cell.
	typedef struct packed {
		logic              append;
		logic              pop;
		logic              clr_dup;
		logic              chk;
		swap_mode_t        mode;
		logic [FloorW-1:0] v;
		logic [FloorW-1:0] c;
	} cell_ctl_t;

endpackage

// ----- rtl/ecl_cell.sv -----
`timescale 1ns / 1ps

module ecl_cell
	import ecl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic              f_valid,
	input  logic [FloorW-1:0] f_val,
	input  logic              f_swap,
	input  logic              f_dup,
	input  logic              b_valid,
	input  logic [FloorW-1:0] b_val,
	input  logic              b_bub,
	output logic              valid,
	output logic [FloorW-1:0] val,
	output logic              bub,
	output logic              swap,
	output logic              dup
);

	logic              valid_q, bub_q, dup_q;
	logic [FloorW-1:0] val_q;
	logic              cond;
	logic              tail;

	always_comb begin
		case (ctl.mode)
			MODE_GT:       cond = ctl.v > val_q;
			MODE_LT:       cond = ctl.v < val_q;
			MODE_GT_BELOW: cond = (ctl.v > val_q) && (val_q < ctl.c);
			MODE_LT_ABOVE: cond = (ctl.v < val_q) && (val_q > ctl.c);
			default:       cond = 1'b0;
		endcase
	end

	// This cell hands its floor back when the new floor sits behind it and wins.
	assign swap = b_bub && valid_q && cond;
	assign tail = !valid_q && f_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			bub_q   <= 1'b0;
			dup_q   <= 1'b0;
		end else begin
			if (ctl.pop) begin
				valid_q <= b_valid;
				bub_q   <= 1'b0;
			end else if (ctl.append) begin
				if (tail) begin
					valid_q <= 1'b1;
				end
				bub_q <= tail;
			end else if (swap) begin
				bub_q <= 1'b1;
			end else if (f_swap) begin
				bub_q <= 1'b0;
			end
			if (ctl.clr_dup) begin
				dup_q <= 1'b0;
			end else if (ctl.chk) begin
				dup_q <= f_dup || (valid_q && (val_q == ctl.v));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			val_q <= b_val;
		end else if (ctl.append) begin
			if (tail) begin
				val_q <= ctl.v;
			end
		end else if (swap) begin
			val_q <= ctl.v;
		end else if (f_swap) begin
			val_q <= f_val;
		end
	end

	assign valid = valid_q;
	assign val   = val_q;
	assign bub   = bub_q;
	assign dup   = dup_q;

endmodule

// ----- rtl/elevator_car_look_stop_queue.sv -----
`timescale 1ns / 1ps
// Timing: a tick's result can be taken in the cycle after acceptance; a stored stop request
// runs a duplicate scan, then two bubbling passes through the row of cells, and a refused
// request only the duplicate scan.
// Throughput: one item at a time, the next taken at the edge where the result leaves; ticks
// run one per cycle unless the result side stalls; a request holds the input off until done.
// Reset: asynchronous, active low; the list empties, the car stands at floor 0 heading up.

module elevator_car_look_stop_queue
	import ecl_pkg::*;
#(
	parameter int NUM_FLOORS = NumFloorsDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [FloorW-1:0] floor,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	output logic [FloorW-1:0] car_floor,
	output logic              moving_down,
	output logic              boarding,
	output logic [FloorW-1:0] target_floor,
	output logic [PendW-1:0]  pending
);

	localparam int CntW = $clog2(NUM_FLOORS + 1);
	localparam logic [CntW-1:0] NumCnt  = CntW'(NUM_FLOORS);
	localparam logic [CntW-1:0] LastCnt = CntW'(NUM_FLOORS - 1);

	state_t            state_q, state_d;
	logic [CntW-1:0]   cnt_q;
	logic [CntW-1:0]   count_q;
	logic [FloorW-1:0] cur_q, tgt_q, v_q;
	logic              down_q, board_q, acc_q, out_valid_q;

	cell_ctl_t         ctl;
	logic              accept_in;
	logic              do_append, finish;
	swap_mode_t        mode_a, mode_b;

	// Row of cells; index 0 is the front of the list, served next.
	logic                  c_valid [NUM_FLOORS];
	logic [FloorW-1:0]     c_val   [NUM_FLOORS];
	logic                  c_bub   [NUM_FLOORS];
	logic                  c_swap  [NUM_FLOORS];
	logic                  c_dup   [NUM_FLOORS];

	// A waiting result holds the input off only while it is itself held off; once it
	// leaves, the next item may enter at that same edge.
	assign accept_in = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);

	// LOOK ordering: the first pass moves the new floor past stops on the far side
	// of the car; the second places a floor ahead of the car in the current sweep.
	always_comb begin
		mode_a = MODE_NONE;
		mode_b = MODE_NONE;
		if (!down_q && v_q > cur_q) begin
			mode_a = MODE_GT_BELOW;
			mode_b = MODE_LT;
		end else if (!down_q && v_q < cur_q) begin
			mode_a = MODE_GT;
		end else if (down_q && v_q < cur_q) begin
			mode_a = MODE_LT_ABOVE;
			mode_b = MODE_GT;
		end else if (down_q && v_q > cur_q) begin
			mode_a = MODE_LT;
		end
	end

	always_comb begin
		state_d     = state_q;
		do_append   = 1'b0;
		finish      = 1'b0;
		ctl.append  = 1'b0;
		ctl.pop     = 1'b0;
		ctl.clr_dup = 1'b0;
		ctl.chk     = 1'b0;
		ctl.mode    = MODE_NONE;
		ctl.v       = v_q;
		ctl.c       = cur_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_in) begin
					if (func) begin
						finish = 1'b1;
						// A car standing at its target takes the front stop.
						ctl.pop = (cur_q == tgt_q) && (count_q != '0);
					end else begin
						ctl.clr_dup = 1'b1;
						state_d     = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (cnt_q == NumCnt) begin
					if (!c_dup[NUM_FLOORS-1] && (count_q != NumCnt)) begin
						do_append  = 1'b1;
						ctl.append = 1'b1;
						state_d    = ST_PHA;
					end else begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end
				end else begin
					ctl.chk = 1'b1;
				end
			end
			ST_PHA: begin
				ctl.mode = mode_a;
				if (cnt_q == LastCnt) begin
					state_d = ST_PHB;
				end
			end
			ST_PHB: begin
				ctl.mode = mode_b;
				if (cnt_q == LastCnt) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			count_q     <= '0;
			cur_q       <= '0;
			tgt_q       <= '0;
			down_q      <= 1'b0;
			board_q     <= 1'b0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q != ST_IDLE) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE && accept_in) begin
				acc_q <= 1'b0;
				if (func) begin
					if (cur_q != tgt_q) begin
						board_q <= 1'b0;
						if (tgt_q > cur_q) begin
							down_q <= 1'b0;
							cur_q  <= cur_q + 1'b1;
						end else begin
							down_q <= 1'b1;
							cur_q  <= cur_q - 1'b1;
						end
					end else begin
						board_q <= 1'b1;
						if (count_q != '0) begin
							tgt_q   <= c_val[0];
							count_q <= count_q - 1'b1;
						end else begin
							tgt_q <= '0;
						end
					end
				end
			end
			if (do_append) begin
				acc_q   <= 1'b1;
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			v_q <= floor;
		end
	end

	for (genvar i = 0; i < NUM_FLOORS; i++) begin : g_cell
		logic              f_valid, f_swap, f_dup, b_valid, b_bub;
		logic [FloorW-1:0] f_val, b_val;
		if (i == 0) begin : g_front
			assign f_valid = 1'b1;
			assign f_val   = '0;
			assign f_swap  = 1'b0;
			assign f_dup   = 1'b0;
		end else begin : g_mid
			assign f_valid = c_valid[i-1];
			assign f_val   = c_val[i-1];
			assign f_swap  = c_swap[i-1];
			assign f_dup   = c_dup[i-1];
		end
		if (i == NUM_FLOORS - 1) begin : g_back
			assign b_valid = 1'b0;
			assign b_val   = '0;
			assign b_bub   = 1'b0;
		end else begin : g_inner
			assign b_valid = c_valid[i+1];
			assign b_val   = c_val[i+1];
			assign b_bub   = c_bub[i+1];
		end
		ecl_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.f_valid (f_valid),
			.f_val   (f_val),
			.f_swap  (f_swap),
			.f_dup   (f_dup),
			.b_valid (b_valid),
			.b_val   (b_val),
			.b_bub   (b_bub),
			.valid   (c_valid[i]),
			.val     (c_val[i]),
			.bub     (c_bub[i]),
			.swap    (c_swap[i]),
			.dup     (c_dup[i])
		);
	end

	// Results mirror the state, which holds while a result waits.
	assign out_valid    = out_valid_q;
	assign accepted     = acc_q;
	assign car_floor    = cur_q;
	assign moving_down  = down_q;
	assign boarding     = board_q;
	assign target_floor = tgt_q;
	assign pending      = PendW'(count_q);

	logic [NUM_FLOORS-1:0] bub_vec;
	for (genvar i = 0; i < NUM_FLOORS; i++) begin : g_bv
		assign bub_vec[i] = c_bub[i];
	end

	a_bub_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(bub_vec))
		else $error("more than one cell holds the new floor");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NumCnt)
		else $error("stop count beyond list depth");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall && !out_valid_q)
		else $error("item taken or result shown while busy");

	a_front_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) == c_valid[0])
		else $error("front cell validity disagrees with stop count");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for one elevator car with a sweep-ordered stop list.
// Stop requests and ticks are sent one item at a time over a valid/stall
// channel. A behavioural model of the car inside this module predicts each
// result, and every result that the block returns is checked field by field
// against the oldest prediction. Both sides insert random idle bursts; one
// test holds the result side off for a long stretch so that the block backs
// up, and another lets every outstanding result drain before it continues.

module tb_top;
	import ecl_pkg::*;

	// One predicted result, laid out as the block's output fields.
	typedef struct packed {
		logic              accepted;
		logic [FloorW-1:0] car_floor;
		logic              moving_down;
		logic              boarding;
		logic [FloorW-1:0] target_floor;
		logic [PendW-1:0]  pending;
	} car_status_t;

	localparam logic FUNC_REQUEST = 1'b0;
	localparam logic FUNC_TICK    = 1'b1;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              func;
	logic [FloorW-1:0] floor;
	logic              out_valid;
	logic              out_stall;
	logic              accepted;
	logic [FloorW-1:0] car_floor;
	logic              moving_down;
	logic              boarding;
	logic [FloorW-1:0] target_floor;
	logic [PendW-1:0]  pending;

	// Model state of the car.
	logic [FloorW-1:0] stops [NumFloorsDef];
	int                n_stops;
	logic [FloorW-1:0] m_floor;
	logic [FloorW-1:0] m_target;
	logic              m_down;
	logic              m_boarding;

	car_status_t status_q[$];
	int          n_errors;
	int          n_results;
	int          n_requests;
	int          n_ticks;
	int          n_refused;
	bit          sender_idles;
	bit          receiver_idles;
	bit          hold_receiver;
	int          hold_cycles;

	elevator_car_look_stop_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.floor       (floor),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.accepted    (accepted),
		.car_floor   (car_floor),
		.moving_down (moving_down),
		.boarding    (boarding),
		.target_floor(target_floor),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The run must finish well inside this, counting the stalls on either side.
	initial begin
		#40_000_000;
		$display("Timeout at %0t", $time);
		$display("*** FAILED ***");
		$finish;
	end

	// Swap the stop at position p with its front neighbour.
	function automatic void swap_with_front(int p);
		logic [FloorW-1:0] t;
		t = stops[p];
		stops[p] = stops[p-1];
		stops[p-1] = t;
	endfunction

	// Insert a floor into the sweep-ordered list. Returns 0 if it is refused.
	function automatic bit insert_stop(logic [FloorW-1:0] v);
		int                p;
		logic [FloorW-1:0] c;
		c = m_floor;
		if (n_stops >= NumFloorsDef)
			return 1'b0;
		for (int i = 0; i < n_stops; i++)
			if (stops[i] == v)
				return 1'b0;
		p = n_stops;
		stops[p] = v;
		n_stops++;
		if (!m_down && v > c) begin
			// Going up, floor above: pass the stops below the car, then
			// take its place in the ascending run.
			while (p > 0 && v > stops[p-1] && stops[p-1] < c) begin
				swap_with_front(p);
				p--;
			end
			while (p > 0 && v < stops[p-1]) begin
				swap_with_front(p);
				p--;
			end
		end else if (!m_down && v < c) begin
			while (p > 0 && v > stops[p-1]) begin
				swap_with_front(p);
				p--;
			end
		end else if (m_down && v < c) begin
			// The mirror image of the upward case above.
			while (p > 0 && v < stops[p-1] && stops[p-1] > c) begin
				swap_with_front(p);
				p--;
			end
			while (p > 0 && v > stops[p-1]) begin
				swap_with_front(p);
				p--;
			end
		end else if (m_down && v > c) begin
			while (p > 0 && v < stops[p-1]) begin
				swap_with_front(p);
				p--;
			end
		end
		// A floor equal to the car's own floor stays at the back.
		return 1'b1;
	endfunction

	// Advance the car by one item and return what the block should report.
	function automatic car_status_t car_next(logic f, logic [FloorW-1:0] fl);
		car_status_t s;
		s.accepted = 1'b0;
		if (f == FUNC_REQUEST) begin
			s.accepted = insert_stop(fl);
		end else if (m_floor != m_target) begin
			m_boarding = 1'b0;
			m_down = !(m_target > m_floor);
			m_floor = m_down ? m_floor - 1'b1 : m_floor + 1'b1;
		end else begin
			// At the target: doors open and the next stop becomes the target.
			m_boarding = 1'b1;
			if (n_stops == 0) begin
				m_target = '0;
			end else begin
				m_target = stops[0];
				for (int i = 1; i < n_stops; i++)
					stops[i-1] = stops[i];
				n_stops--;
			end
		end
		s.car_floor    = m_floor;
		s.moving_down  = m_down;
		s.boarding     = m_boarding;
		s.target_floor = m_target;
		s.pending      = PendW'(n_stops);
		return s;
	endfunction

	// Offer one item, hold it until accepted, and record its prediction.
	// Called at a falling edge; the input is dropped at the falling edge after
	// acceptance and raised again at once by the next call unless it idles.
	task automatic send_item(logic f, logic [FloorW-1:0] fl);
		car_status_t s;
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		in_valid = 1'b1;
		func     = f;
		floor    = fl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		s = car_next(f, fl);
		status_q.push_back(s);
		if (f == FUNC_TICK)
			n_ticks++;
		else begin
			n_requests++;
			if (!s.accepted)
				n_refused++;
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_request(logic [FloorW-1:0] fl);
		send_item(FUNC_REQUEST, fl);
	endtask

	// A tick carries a random floor field, since the block must ignore it.
	task automatic send_tick();
		send_item(FUNC_TICK, FloorW'($urandom));
	endtask

	task automatic wait_drained();
		while (status_q.size() != 0)
			@(negedge clk);
	endtask

	// Result side: the stall toggles in bursts, or is held by a test.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_receiver) begin
				out_stall <= 1'b1;
				hold_cycles++;
			end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17) - 1) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Check every accepted result against the oldest prediction.
	always @(posedge clk) begin
		car_status_t s;
		car_status_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {accepted, car_floor, moving_down, boarding, target_floor, pending};
			if (status_q.size() == 0) begin
				$display("%0t: result with nothing expected: %h", $time, got);
				n_errors++;
			end else begin
				s = status_q.pop_front();
				n_results++;
				if (got.accepted !== s.accepted) begin
					$display("%0t: accepted expected %0d actual %0d", $time,
						s.accepted, got.accepted);
					n_errors++;
				end
				if (got.car_floor !== s.car_floor) begin
					$display("%0t: car_floor expected %0d actual %0d", $time,
						s.car_floor, got.car_floor);
					n_errors++;
				end
				if (got.moving_down !== s.moving_down) begin
					$display("%0t: moving_down expected %0d actual %0d", $time,
						s.moving_down, got.moving_down);
					n_errors++;
				end
				if (got.boarding !== s.boarding) begin
					$display("%0t: boarding expected %0d actual %0d", $time,
						s.boarding, got.boarding);
					n_errors++;
				end
				if (got.target_floor !== s.target_floor) begin
					$display("%0t: target_floor expected %0d actual %0d", $time,
						s.target_floor, got.target_floor);
					n_errors++;
				end
				if (got.pending !== s.pending) begin
					$display("%0t: pending expected %0d actual %0d", $time,
						s.pending, got.pending);
					n_errors++;
				end
			end
		end
	end

	// Extremes, duplicates, a floor equal to the car's, and floors above
	// and below the car while it is driven up.
	task automatic test_directed();
		send_tick();            // empty list: target stays at floor 0
		send_request(7'd0);     // equal to the car's floor
		send_request(7'd0);     // duplicate
		send_request(7'd127);
		send_request(7'd5);
		send_request(7'd3);
		send_request(7'd5);     // duplicate
		send_tick();            // pop floor 0
		send_tick();            // pop the next stop
		repeat (4) send_tick(); // move up to floor 3 and pop the next stop
		send_request(7'd1);     // below the car while going up
		send_request(7'd2);
		send_request(7'd64);    // above the car while going up
		repeat (6) send_tick();
	endtask

	// Mostly bursts of requests followed by runs of ticks, so that the car
	// sweeps both ways with a well-filled list.
	task automatic test_random(int n_items, bit narrow);
		int k;
		k = 0;
		while (k < n_items) begin
			if ($urandom_range(0, 2) != 0) begin
				repeat ($urandom_range(1, 6)) begin
					send_request(narrow ? FloorW'($urandom_range(0, 15))
						: FloorW'($urandom));
					k++;
				end
			end else begin
				repeat ($urandom_range(1, 20)) begin
					send_tick();
					k++;
				end
			end
		end
	endtask

	// Keep the result side stalled while items keep coming, so the block
	// backs up and stalls its input.
	task automatic test_backpressure();
		fork
			begin
				hold_cycles = 0;
				hold_receiver = 1'b1;
				while (hold_cycles < 3000)
					@(negedge clk);
				hold_receiver = 1'b0;
			end
			begin
				repeat (12) send_tick();
			end
		join
	endtask

	// Fill the list with every floor; one more request is then refused.
	task automatic test_full_list();
		for (int i = 0; i < NumFloorsDef; i++)
			send_request(FloorW'(i));
		send_request(7'd127);
		// Sender stops until every result is in.
		wait_drained();
		repeat (200) send_tick();
	endtask

	initial begin
		n_errors       = 0;
		n_results      = 0;
		n_requests     = 0;
		n_ticks        = 0;
		n_refused      = 0;
		hold_receiver  = 1'b0;
		hold_cycles    = 0;
		sender_idles   = 1'b1;
		receiver_idles = 1'b1;
		in_valid       = 1'b0;
		func           = FUNC_REQUEST;
		floor          = '0;
		arst_n         = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_backpressure();
		test_random(150, 1'b1);
		wait_drained();
		test_random(100, 1'b0);
		test_full_list();
		// The last part runs with no idling on either side.
		sender_idles   = 1'b0;
		receiver_idles = 1'b0;
		test_random(100, 1'b0);

		wait_drained();
		repeat (50) @(negedge clk);
		$display("Covered %0d requests (%0d refused) and %0d ticks, %0d results checked.",
			n_requests, n_refused, n_ticks, n_results);
		$display("Included a full stop list, a long result stall and a drained pause.");
		if (n_errors == 0 && status_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", n_errors, status_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
